### rtl/osmt_pkg.sv
package osmt_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int VAL_W = 32;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_LOOKUP = 2'd2;

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic valid;
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

### rtl/osmt_cell.sv
module osmt_cell (
  input  logic                clk,
  input  osmt_pkg::cell_ctrl_t ctrl,
  input  osmt_pkg::val_t      key,
  input  osmt_pkg::val_t      neighbor,
  output osmt_pkg::val_t      data,
  output logic                match
);

  osmt_pkg::val_t data_r;
  osmt_pkg::val_t data_nxt;

  assign data  = data_r;
  assign match = ctrl.valid && (data_r == key);

  always_comb begin
    data_nxt = data_r;
    if (ctrl.load) begin
      data_nxt = key;
    end else if (ctrl.shift) begin
      data_nxt = neighbor;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

### rtl/osmt_encoder.sv
module osmt_encoder (
  input  logic [osmt_pkg::CAPACITY-1:0] match,
  output logic                          hit,
  output osmt_pkg::idx_t                pos
);

  // lowest matching cell wins
  always_comb begin
    hit = |match;
    pos = '0;
    for (int i = osmt_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        pos = osmt_pkg::IDX_W'(i);
      end
    end
  end

endmodule

### rtl/ordered_set_membership_table.sv
// Ordered set table: holds up to 16 distinct signed 32-bit values in insertion
// order, one value per cell of a row of cells. A request (in_func, in_value) is
// taken when start is high and busy is low; busy then stays high for one cycle
// while every cell compares its value with the key, the lowest match is
// encoded, and the row is updated (append at the tail on insert, shift of the
// later cells down one place on remove). The result appears on the out_ ports
// for exactly one cycle, marked by out_valid, on the cycle after busy; it is not
// held and the receiver cannot stall it. A new request cannot be taken while busy
// is high, and one may be started in the same cycle its result is shown.
// Unused func code 3 acts as a lookup.
module ordered_set_membership_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_func,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  output logic               out_was_present,
  output logic [3:0]         out_found_position,
  output logic [4:0]         out_element_count,
  output logic               out_full_dropped
);

  localparam int CAP = osmt_pkg::CAPACITY;

  logic           busy_r;
  logic           out_valid_r;
  logic [1:0]     func_r;
  osmt_pkg::val_t key_r;
  osmt_pkg::cnt_t occ_r;
  osmt_pkg::cnt_t occ_nxt;

  logic           was_present_r;
  logic [3:0]     found_position_r;
  logic [4:0]     element_count_r;
  logic           full_dropped_r;

  osmt_pkg::cell_ctrl_t ctrl   [CAP];
  osmt_pkg::val_t       c_data [CAP];
  logic [CAP-1:0]       match;
  logic                 hit;
  osmt_pkg::idx_t       pos;
  logic                 do_insert;
  logic                 do_remove;
  logic                 dropped;

  assign busy = busy_r;

  osmt_encoder u_enc (
    .match (match),
    .hit   (hit),
    .pos   (pos)
  );

  always_comb begin
    do_insert = 1'b0;
    do_remove = 1'b0;
    dropped   = 1'b0;
    case (func_r)
      osmt_pkg::FUNC_INSERT: begin
        if (!hit) begin
          if (occ_r < osmt_pkg::CNT_W'(CAP)) begin
            do_insert = busy_r;
          end else begin
            dropped = 1'b1;
          end
        end
      end
      osmt_pkg::FUNC_REMOVE: begin
        do_remove = busy_r && hit;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    occ_nxt = occ_r;
    if (do_insert) begin
      occ_nxt = occ_r + osmt_pkg::CNT_W'(1);
    end else if (do_remove) begin
      occ_nxt = occ_r - osmt_pkg::CNT_W'(1);
    end
  end

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    localparam osmt_pkg::cnt_t IDX = osmt_pkg::CNT_W'(i);

    assign ctrl[i].valid = IDX < occ_r;
    assign ctrl[i].load  = do_insert && (IDX == occ_r);
    assign ctrl[i].shift = do_remove && (IDX >= osmt_pkg::CNT_W'(pos))
                           && (IDX + osmt_pkg::CNT_W'(1) < occ_r);

    osmt_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl[i]),
      .key      (key_r),
      .neighbor (c_data[(i + 1 < CAP) ? i + 1 : i]),
      .data     (c_data[i]),
      .match    (match[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      occ_r       <= '0;
    end else begin
      busy_r      <= start && !busy_r;
      out_valid_r <= busy_r;
      occ_r       <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      func_r <= in_func;
      key_r  <= osmt_pkg::val_t'(in_value);
    end
    if (busy_r) begin
      was_present_r    <= hit;
      found_position_r <= 4'(pos);
      element_count_r  <= 5'(occ_nxt);
      full_dropped_r   <= dropped;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_was_present    = was_present_r;
  assign out_found_position = found_position_r;
  assign out_element_count  = element_count_r;
  assign out_full_dropped   = full_dropped_r;

`ifndef NO_ASSERTIONS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= osmt_pkg::CNT_W'(CAP))
    else $error("occupancy above capacity");

  a_result_follows_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy_r))
    else $error("result strobe without a transaction in work");

  a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_full_dropped |->
      !out_was_present && (out_element_count == 5'(CAP)))
    else $error("drop flagged on a table that is not full");

  a_absent_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_was_present |-> out_found_position == 4'd0)
    else $error("position reported for an absent value");

  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && (func_r == osmt_pkg::FUNC_REMOVE) && hit |=>
      occ_r == $past(occ_r) - osmt_pkg::CNT_W'(1))
    else $error("remove of present value did not shrink the table");
`endif

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  // func code 3 is not decoded by the block and must act as a lookup
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int STALL_LIMIT = 1000;
  localparam int POOL_SIZE = 24;

  typedef struct packed {
    logic was_present;
    osmt_pkg::idx_t pos;
    osmt_pkg::cnt_t count;
    logic dropped;
  } answer_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           start = 1'b0;
  logic [1:0]     in_func = osmt_pkg::FUNC_LOOKUP;
  osmt_pkg::val_t in_value = '0;
  logic           busy;
  logic           out_valid;
  logic           out_was_present;
  logic [3:0]     out_found_position;
  logic [4:0]     out_element_count;
  logic           out_full_dropped;

  ordered_set_membership_table dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_func            (in_func),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_was_present    (out_was_present),
    .out_found_position (out_found_position),
    .out_element_count  (out_element_count),
    .out_full_dropped   (out_full_dropped)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the set, in insertion order
  osmt_pkg::val_t set_vals [osmt_pkg::CAPACITY];
  int             set_size = 0;
  answer_t        answers_q [$];
  osmt_pkg::val_t pool [POOL_SIZE];
  bit             idle_on = 1'b1;
  int             errors = 0;
  int             n_checked = 0;
  int             n_hits = 0;
  int             n_drops = 0;
  int             n_removes = 0;
  int             stall = 0;

  function automatic answer_t lookup_and_update(input logic [1:0] f,
                                                input osmt_pkg::val_t v);
    answer_t a;
    int i;
    a = '0;
    for (i = 0; i < set_size; i++) begin
      if (!a.was_present && set_vals[i] == v) begin
        a.was_present = 1'b1;
        a.pos = osmt_pkg::idx_t'(i);
      end
    end
    case (f)
      osmt_pkg::FUNC_INSERT: begin
        if (!a.was_present) begin
          if (set_size < osmt_pkg::CAPACITY) begin
            set_vals[set_size] = v;
            set_size++;
          end else begin
            a.dropped = 1'b1;
          end
        end
      end
      osmt_pkg::FUNC_REMOVE: begin
        if (a.was_present) begin
          for (i = int'(a.pos); i + 1 < set_size; i++) set_vals[i] = set_vals[i + 1];
          set_size--;
        end
      end
      default: ;
    endcase
    a.count = osmt_pkg::cnt_t'(set_size);
    return a;
  endfunction

  task automatic send_request(input logic [1:0] f, input osmt_pkg::val_t v);
    answer_t expect_a;
    while (idle_on && $urandom_range(99) < 22) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_func <= f;
    in_value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    expect_a = lookup_and_update(f, v);
    answers_q = {answers_q, expect_a};
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (answers_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid) begin
      if (answers_q.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        want = answers_q.pop_front();
        n_checked++;
        if (out_was_present) n_hits++;
        if (out_full_dropped) n_drops++;
        if (out_was_present !== want.was_present) begin
          $error("was_present: expected %0d, got %0d", want.was_present, out_was_present);
          errors++;
        end
        if (out_found_position !== want.pos) begin
          $error("found_position: expected %0d, got %0d", want.pos, out_found_position);
          errors++;
        end
        if (out_element_count !== want.count) begin
          $error("element_count: expected %0d, got %0d", want.count, out_element_count);
          errors++;
        end
        if (out_full_dropped !== want.dropped) begin
          $error("full_dropped: expected %0d, got %0d", want.dropped, out_full_dropped);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles with neither a request nor a result transaction
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) stall <= 0;
    else stall <= stall + 1;
    if (stall >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_empty_table();
    send_request(osmt_pkg::FUNC_LOOKUP, 32'd5);
    send_request(osmt_pkg::FUNC_REMOVE, 32'd5);
  endtask

  task automatic test_single_ops();
    send_request(osmt_pkg::FUNC_INSERT, 32'h8000_0000);
    send_request(osmt_pkg::FUNC_INSERT, 32'h7fff_ffff);
    send_request(osmt_pkg::FUNC_INSERT, 32'h0000_0000);
    send_request(osmt_pkg::FUNC_INSERT, 32'hffff_ffff);
    send_request(osmt_pkg::FUNC_INSERT, 32'h7fff_ffff);
    send_request(osmt_pkg::FUNC_LOOKUP, 32'hffff_ffff);
    send_request(FUNC_SPARE, 32'h0000_0000);
    // middle, then first, then last entry
    send_request(osmt_pkg::FUNC_REMOVE, 32'h0000_0000);
    send_request(osmt_pkg::FUNC_REMOVE, 32'h8000_0000);
    send_request(osmt_pkg::FUNC_REMOVE, 32'hffff_ffff);
  endtask

  task automatic test_full_table();
    int i;
    wait_drained();
    for (i = 0; i < osmt_pkg::CAPACITY - 1; i++) begin
      send_request(osmt_pkg::FUNC_INSERT, osmt_pkg::val_t'(100 + 7 * i));
    end
    send_request(osmt_pkg::FUNC_INSERT, 32'd99);
    send_request(osmt_pkg::FUNC_INSERT, 32'd100);
    send_request(osmt_pkg::FUNC_REMOVE, 32'd99);
    send_request(osmt_pkg::FUNC_REMOVE, 32'd100);
    send_request(osmt_pkg::FUNC_INSERT, 32'd99);
  endtask

  task automatic run_phase(input int n, input int ins_pct, input int rem_pct);
    int k;
    int r;
    logic [1:0] f;
    osmt_pkg::val_t v;
    for (k = 0; k < POOL_SIZE; k++) pool[k] = $urandom();
    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7fff_ffff;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < ins_pct) f = osmt_pkg::FUNC_INSERT;
      else if (r < ins_pct + rem_pct) f = osmt_pkg::FUNC_REMOVE;
      else if (r < 96) f = osmt_pkg::FUNC_LOOKUP;
      else f = FUNC_SPARE;
      // mostly values from a small pool so hits and a full table are common
      if ($urandom_range(99) < 88) v = pool[$urandom_range(POOL_SIZE - 1)];
      else v = $urandom();
      send_request(f, v);
    end
    wait_drained();
  endtask

  task automatic test_random_traffic();
    run_phase(160, 65, 20);
    idle_on = 1'b0;
    run_phase(160, 25, 55);
    idle_on = 1'b1;
    run_phase(165, 45, 35);
    run_phase(165, 50, 40);
  endtask

  always @(posedge clk) begin
    if (rst_n && start && !busy && in_func == osmt_pkg::FUNC_REMOVE) n_removes++;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_single_ops();
    test_full_table();
    test_random_traffic();
    wait_drained();
    $display("checked %0d results from insert, remove and lookup transactions", n_checked);
    $display("  %0d hits, %0d remove requests, %0d inserts refused on a full table",
             n_hits, n_removes, n_drops);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
